// File: design/twtvs_pkg.sv
package twtvs_pkg;

   localparam int OP_W       = 2;
   localparam int TIME_W     = 27;
   localparam int SIZE_W     = 32;
   localparam int SEC_W      = 16;
   localparam int TOTAL_W    = 48;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 27;

   // request opcodes
   localparam logic [OP_W-1:0] OP_TRADE     = 2'd0;
   localparam logic [OP_W-1:0] OP_INTERRUPT = 2'd1;
   localparam logic [OP_W-1:0] OP_RESUME    = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIDE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WATCHED = 2'd2;

   localparam logic [TIME_W-1:0] WINDOW_RESET = 27'd1000;

   typedef logic signed [TOTAL_W-1:0] total_type;

   typedef struct packed {
      logic [TIME_W-1:0] time_ms;
      logic [SIZE_W-1:0] trade_size;
   } entry_type;

   // saturating add of a signed delta into the 48-bit total
   function automatic total_type sat_add(input total_type a,
                                         input logic signed [SIZE_W:0] b);
      logic signed [TOTAL_W:0] s;
      total_type r;
      s = (TOTAL_W + 1)'(a) + (TOTAL_W + 1)'(b);
      if (s[TOTAL_W] != s[TOTAL_W-1]) begin
         r = s[TOTAL_W] ? {1'b1, {(TOTAL_W - 1){1'b0}}} : {1'b0, {(TOTAL_W - 1){1'b1}}};
      end else begin
         r = s[TOTAL_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: design/twtvs_if.sv
interface twtvs_req_if;
   import twtvs_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [TIME_W-1:0] time_ms;
   logic              trade_side;
   logic [SIZE_W-1:0] trade_size;
   logic [SEC_W-1:0]  symbol_id;
   logic              source_ready;

   modport source (output valid, op, time_ms, trade_side, trade_size, symbol_id,
                   source_ready, input ready);
   modport sink (input valid, op, time_ms, trade_side, trade_size, symbol_id,
                 source_ready, output ready);
endinterface

interface twtvs_rsp_if;
   import twtvs_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [TOTAL_W-1:0] window_total;

   modport source (output valid, window_total, input ready);
   modport sink (input valid, window_total, output ready);
endinterface

// File: design/twtvs_queue_mem.sv
module twtvs_queue_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 59
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read-first, registered read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/time_window_trade_volume_sum.sv
// sequence: a counted trade passes through the evict, append and emit states, with one evict
//   step per expired entry; a watched interrupt goes straight from idle to the emit state
// flow: one expired entry leaves per cycle through the queue memory read port; a new request
//   is taken only in the idle state, after the last one has been emitted; a stalled
//   output beat holds the block in its emit step until the result register frees up
// reset: synchronous, active high; clears queue pointers, total, flags and the output beat,
//   and loads the register defaults; queue memory contents are not cleared
module time_window_trade_volume_sum #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [twtvs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [twtvs_pkg::CSR_DATA_W-1:0]     csr_wdata,
   twtvs_req_if.sink                            req_bus,
   twtvs_rsp_if.source                          rsp_bus
);
   import twtvs_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = PTR_W + 1;
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);
   localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(QUEUE_DEPTH);

   // sequencer states
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_EVICT  = 2'd1;
   localparam logic [1:0] ST_APPEND = 2'd2;
   localparam logic [1:0] ST_EMIT   = 2'd3;

   logic [1:0]        state_ff, state_in;

   // configuration
   logic [TIME_W-1:0] window_ff;
   logic              side_ff;
   logic [SEC_W-1:0]  watched_ff;

   // queue bookkeeping and running state
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   total_type         total_ff, total_in;
   logic              ready_flag_ff, ready_flag_in;
   logic              intr_ff, intr_in;

   // item being worked on
   logic [TIME_W-1:0] now_ff, now_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   total_type         result_ff, result_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   total_type         rsp_total_ff, rsp_total_in;

   // memory side
   logic              mem_we;
   logic [PTR_W-1:0]  tail_ptr;
   logic [SUM_W-1:0]  tail_sum;
   entry_type         wr_entry, rd_entry;
   logic [$bits(entry_type)-1:0] rd_raw;

   logic              accept;
   logic              out_free;
   logic [TIME_W:0]   age;
   logic              expired;
   logic [PTR_W-1:0]  head_step;
   total_type         drop_total;
   total_type         add_total;

   assign accept   = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   assign req_bus.ready        = (state_ff == ST_IDLE);
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.window_total = rsp_total_ff;

   // the head entry is re-read every cycle from the next head pointer, so the
   // read data always belongs to head_ff; a write at the tail lands at least
   // one read before the next item can look at it
   twtvs_queue_mem #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH ($bits(entry_type))
   ) u_queue (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (tail_ptr),
      .wr_data (wr_entry),
      .rd_addr (head_in),
      .rd_data (rd_raw)
   );

   assign rd_entry = entry_type'(rd_raw);

   // age of the oldest entry; negative age never expires
   assign age     = {1'b0, now_ff} - {1'b0, rd_entry.time_ms};
   assign expired = !age[TIME_W] && (age[TIME_W-1:0] >= window_ff);

   assign head_step  = (head_ff == LAST_PTR) ? '0 : head_ff + PTR_W'(1);
   assign drop_total = sat_add(total_ff, -$signed({1'b0, rd_entry.trade_size}));
   assign add_total  = sat_add(total_ff, $signed({1'b0, size_ff}));

   // tail = (head + count) mod depth, sum stays below twice the depth
   assign tail_sum = {1'b0, head_ff} + SUM_W'(count_ff);
   assign tail_ptr = (tail_sum >= DEPTH_SUM) ? PTR_W'(tail_sum - DEPTH_SUM)
                                             : PTR_W'(tail_sum);

   assign wr_entry.time_ms    = now_ff;
   assign wr_entry.trade_size = size_ff;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      ready_flag_in = ready_flag_ff;
      intr_in       = intr_ff;
      now_in        = now_ff;
      size_in       = size_ff;
      result_in     = result_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_total_in  = rsp_total_ff;
      mem_we        = 1'b0;

      // output beat taken
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               now_in  = req_bus.time_ms;
               size_in = req_bus.trade_size;
               case (req_bus.op)
                  OP_TRADE: begin
                     if (!ready_flag_ff) begin
                        // first trade with upstream ready arms the block, no result
                        if (req_bus.source_ready) begin
                           ready_flag_in = 1'b1;
                        end
                     end else if (req_bus.trade_side == side_ff) begin
                        state_in = ST_EVICT;
                     end
                  end
                  OP_INTERRUPT: begin
                     if (req_bus.symbol_id == watched_ff) begin
                        intr_in   = 1'b1;
                        total_in  = '0;
                        result_in = '0;
                        state_in  = ST_EMIT;
                     end
                  end
                  OP_RESUME: begin
                     if (req_bus.symbol_id == watched_ff) begin
                        intr_in = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_EVICT: begin
            // one expired entry leaves per cycle
            if ((count_ff != '0) && expired) begin
               total_in = drop_total;
               head_in  = head_step;
               count_in = count_ff - CNT_W'(1);
            end else begin
               // queue full: oldest goes regardless of age
               if (count_ff == FULL_CNT) begin
                  total_in = drop_total;
                  head_in  = head_step;
                  count_in = count_ff - CNT_W'(1);
               end
               state_in = ST_APPEND;
            end
         end
         ST_APPEND: begin
            mem_we   = 1'b1;
            count_in = count_ff + CNT_W'(1);
            if (intr_ff) begin
               total_in  = '0;
               result_in = '0;
            end else begin
               total_in  = add_total;
               result_in = add_total;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // wait for the output register to free up
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_total_in = result_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         count_ff      <= '0;
         total_ff      <= '0;
         ready_flag_ff <= 1'b0;
         intr_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         total_ff      <= total_in;
         ready_flag_ff <= ready_flag_in;
         intr_ff       <= intr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      now_ff       <= now_in;
      size_ff      <= size_in;
      result_ff    <= result_in;
      rsp_total_ff <= rsp_total_in;
   end

   // register writes; the user must write only while idle, the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= WINDOW_RESET;
         side_ff    <= 1'b0;
         watched_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WINDOW:  window_ff  <= csr_wdata[TIME_W-1:0];
            CSR_SIDE:    side_ff    <= csr_wdata[0];
            CSR_WATCHED: watched_ff <= csr_wdata[SEC_W-1:0];
            default: begin
            end
         endcase
      end
   end

endmodule

// File: design/twtvs_checker.sv
module twtvs_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                csr_we,
   input logic [twtvs_pkg::CSR_IDX_W-1:0]     csr_index,
   input logic [twtvs_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic [twtvs_pkg::OP_W-1:0]          req_op,
   input logic [twtvs_pkg::SEC_W-1:0]         req_symbol_id,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [twtvs_pkg::TOTAL_W-1:0]       rsp_window_total
);
   import twtvs_pkg::*;

   logic [SEC_W-1:0] watched_ff;
   logic             req_beat;

   assign req_beat = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         watched_ff <= '0;
      end else if (csr_we && (csr_index == CSR_WATCHED)) begin
         watched_ff <= csr_wdata[SEC_W-1:0];
      end
   end

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_window_total))
      else $error("result beat dropped or changed while stalled");

   // reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   // a resume never occupies the block
   a_resume_free: assert property (@(posedge clock) disable iff (reset)
      req_beat && (req_op == OP_RESUME) |=> req_ready)
      else $error("block busy after resume");

   // an interrupt for the watched security has a result to deliver
   a_intr_busy: assert property (@(posedge clock) disable iff (reset)
      req_beat && (req_op == OP_INTERRUPT) && (req_symbol_id == watched_ff)
         |=> !req_ready)
      else $error("watched interrupt gave no result work");

endmodule

bind time_window_trade_volume_sum twtvs_checker u_twtvs_checker (
   .clock            (clock),
   .reset            (reset),
   .csr_we           (csr_we),
   .csr_index        (csr_index),
   .csr_wdata        (csr_wdata),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .req_op           (req_bus.op),
   .req_symbol_id    (req_bus.symbol_id),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_window_total (rsp_bus.window_total)
);

// File: tb/tb_time_window_trade_volume_sum.sv
`timescale 1ns / 100ps

typedef struct packed {
   logic [twtvs_pkg::OP_W-1:0]   op;
   logic [twtvs_pkg::TIME_W-1:0] time_ms;
   logic                         trade_side;
   logic [twtvs_pkg::SIZE_W-1:0] trade_size;
   logic [twtvs_pkg::SEC_W-1:0]  symbol_id;
   logic                         source_ready;
} feed_beat_type;

// tracks the windowed volume sum and holds the totals still owed by the block
class window_total_tracker;
   localparam int     SLOTS      = 64;
   localparam int     OWED_SLOTS = 256;
   localparam longint TOTAL_HI   = 64'sd140737488355327;
   localparam longint TOTAL_LO   = -TOTAL_HI - 64'sd1;

   logic [twtvs_pkg::TIME_W-1:0] span_ms;
   bit                           side_sel;
   logic [twtvs_pkg::SEC_W-1:0]  watch_id;

   logic [twtvs_pkg::TIME_W-1:0] slot_time [SLOTS];
   logic [twtvs_pkg::SIZE_W-1:0] slot_size [SLOTS];
   bit [$clog2(SLOTS)-1:0]       oldest;
   int                           used;
   longint                       total;
   bit                           armed;
   bit                           halted;

   // ring of totals still owed by the block
   twtvs_pkg::total_type         owed_totals [OWED_SLOTS];
   int                           owed_head;
   int                           owed_tail;
   int                           mismatches;

   function new();
      span_ms    = twtvs_pkg::WINDOW_RESET;
      side_sel   = 1'b0;
      watch_id   = '0;
      oldest     = '0;
      used       = 0;
      total      = 0;
      armed      = 1'b0;
      halted     = 1'b0;
      owed_head  = 0;
      owed_tail  = 0;
      mismatches = 0;
   endfunction

   function longint clamp(longint v);
      return (v > TOTAL_HI) ? TOTAL_HI : ((v < TOTAL_LO) ? TOTAL_LO : v);
   endfunction

   function void retire_oldest();
      total = clamp(total - longint'(slot_size[oldest]));
      oldest++;
      used--;
   endfunction

   function void owe_total(twtvs_pkg::total_type v);
      owed_totals[owed_tail % OWED_SLOTS] = v;
      owed_tail++;
   endfunction

   function void set_register(logic [twtvs_pkg::CSR_IDX_W-1:0] index,
                              logic [twtvs_pkg::CSR_DATA_W-1:0] data);
      case (index)
         twtvs_pkg::CSR_WINDOW:  span_ms  = data[twtvs_pkg::TIME_W-1:0];
         twtvs_pkg::CSR_SIDE:    side_sel = data[0];
         twtvs_pkg::CSR_WATCHED: watch_id = data[twtvs_pkg::SEC_W-1:0];
         default: ;
      endcase
   endfunction

   function void note_request(feed_beat_type b);
      longint                 age;
      bit [$clog2(SLOTS)-1:0] slot;
      case (b.op)
         twtvs_pkg::OP_TRADE: begin
            // first trade with the upstream flag only arms the block
            if (!armed) begin
               armed = b.source_ready;
               return;
            end
            if (b.trade_side != side_sel) return;
            while (used > 0) begin
               age = longint'(b.time_ms) - longint'(slot_time[oldest]);
               if (age < longint'(span_ms)) break;
               retire_oldest();
            end
            if (used >= SLOTS) retire_oldest();
            slot            = oldest + used[$clog2(SLOTS)-1:0];
            slot_time[slot] = b.time_ms;
            slot_size[slot] = b.trade_size;
            used++;
            total = clamp(total + longint'(b.trade_size));
            if (halted) total = 0;
            owe_total(twtvs_pkg::total_type'(total));
         end
         twtvs_pkg::OP_INTERRUPT: begin
            if (b.symbol_id == watch_id) begin
               halted = 1'b1;
               total  = 0;
               owe_total('0);
            end
         end
         twtvs_pkg::OP_RESUME: begin
            if (b.symbol_id == watch_id) halted = 1'b0;
         end
         default: ;
      endcase
   endfunction

   function void check_total(twtvs_pkg::total_type got);
      twtvs_pkg::total_type want;
      if (owed_tail == owed_head) begin
         $display("%0t: window_total %0d arrived with nothing expected", $time, got);
         mismatches++;
         return;
      end
      want = owed_totals[owed_head % OWED_SLOTS];
      owed_head++;
      if (got !== want) begin
         $display("%0t: window_total mismatch, expected %0d actual %0d", $time, want, got);
         mismatches++;
      end
   endfunction

   function int pending();
      return owed_tail - owed_head;
   endfunction
endclass

module tb_time_window_trade_volume_sum;
   import twtvs_pkg::*;

   // op code the block must ignore
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

   localparam int TIME_MAX      = 86399999;
   localparam int WINDOW_MAX    = 86400000;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 141;
   // a counted trade retires at most 64 entries before its result is emitted
   localparam int SETTLE_CYCLES = 16;
   localparam int TAIL_CYCLES   = 80;
   localparam int HOLD_CYCLES   = 300;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   twtvs_req_if req_bus ();
   twtvs_rsp_if rsp_bus ();

   window_total_tracker tracker = new();

   // idle rates in percent, changed between phases
   int send_idle_pct = 28;
   int recv_idle_pct = 80;

   // long receiver stall, requested by the stimulus and counted by the receiver
   bit hold_request = 1'b0;
   int hold_left;

   // stimulus-side view of the settings, used only to shape the random traffic
   logic [TIME_W-1:0] window_len   = WINDOW_RESET;
   bit                counted_side = 1'b0;
   logic [SEC_W-1:0]  watched_id   = '0;
   longint            feed_time    = 0;

   time_window_trade_volume_sum dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #(5_000_000);
      $display("Regression FAIL");
      $finish;
   end

   function automatic feed_beat_type make_beat(logic [OP_W-1:0] op, int unsigned t, int side,
                                               logic [SIZE_W-1:0] size, logic [SEC_W-1:0] sec,
                                               int rdy);
      feed_beat_type b;
      b.op           = op;
      b.time_ms      = TIME_W'(t);
      b.trade_side   = 1'(side);
      b.trade_size   = size;
      b.symbol_id    = sec;
      b.source_ready = 1'(rdy);
      return b;
   endfunction

   // mostly counted trades on a moving clock, plus interrupts, resumes and noise
   function automatic feed_beat_type random_beat();
      feed_beat_type b;
      int            roll;
      int            pick;
      longint        w;
      longint        gap_ms;
      b.op           = OP_TRADE;
      b.time_ms      = TIME_W'($urandom_range(0, TIME_MAX));
      b.trade_side   = 1'($urandom_range(1));
      b.trade_size   = $urandom();
      b.symbol_id    = SEC_W'($urandom());
      b.source_ready = 1'($urandom_range(1));
      roll = $urandom_range(99);
      if (roll < 80) begin
         // trades: most on the counted side
         b.trade_side = (roll < 72) ? counted_side : !counted_side;
         w    = longint'(window_len);
         pick = $urandom_range(99);
         if (pick < 55) gap_ms = longint'($urandom_range(0, 32'(w / 16 + 2)));
         else if (pick < 88) gap_ms = longint'($urandom_range(0, 4));
         else if (pick < 97)
            gap_ms = longint'($urandom_range(32'(w / 2), 32'(w + w / 2 + 2)));
         else gap_ms = -1;
         // clock running backwards, or wrapping past midnight
         if (gap_ms < 0) feed_time = longint'($urandom_range(0, 32'(feed_time)));
         else if (feed_time + gap_ms > TIME_MAX) feed_time = longint'($urandom_range(0, 2000));
         else feed_time = feed_time + gap_ms;
         b.time_ms = TIME_W'(feed_time);
         pick = $urandom_range(99);
         if (pick < 15) b.trade_size = '0;
         else if (pick < 30) b.trade_size = '1;
         else if (pick < 60) b.trade_size = $urandom_range(1, 1000);
      end else if (roll < 87) begin
         b.op = OP_INTERRUPT;
         if ($urandom_range(3) != 0) b.symbol_id = watched_id;
      end else if (roll < 96) begin
         b.op = OP_RESUME;
         if ($urandom_range(3) != 0) b.symbol_id = watched_id;
      end else begin
         b.op = OP_SPARE;
      end
      return b;
   endfunction

   // offer one beat, with random idle cycles ahead of it, and wait for the handshake
   task automatic send_request(input feed_beat_type b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.op           <= b.op;
      req_bus.time_ms      <= b.time_ms;
      req_bus.trade_side   <= b.trade_side;
      req_bus.trade_size   <= b.trade_size;
      req_bus.symbol_id    <= b.symbol_id;
      req_bus.source_ready <= b.source_ready;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      tracker.note_request(b);
   endtask

   // stop sending, wait for every owed total, then let the block settle
   task automatic await_idle(input int settle);
      req_bus.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      tracker.set_register(index, data);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // receiver: checks every accepted total, stalls at random or for a long hold
   initial begin
      rsp_bus.ready = 1'b0;
      hold_left     = 0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            tracker.check_total(rsp_bus.window_total);
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_index            = '0;
      csr_wdata            = '0;
      req_bus.valid        = 1'b0;
      req_bus.op           = OP_TRADE;
      req_bus.time_ms      = '0;
      req_bus.trade_side   = 1'b0;
      req_bus.trade_size   = '0;
      req_bus.symbol_id    = '0;
      req_bus.source_ready = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, reset settings: 1000 ms window, buy side, security 0
      // spare op code with every other field at its top
      send_request(make_beat(OP_SPARE, TIME_MAX, 1, 32'hFFFF_FFFF, 16'hFFFF, 1));
      // trade while not ready and upstream not ready: nothing happens
      send_request(make_beat(OP_TRADE, 0, 0, 32'd5, 16'd0, 0));
      // interrupt for another security is ignored
      send_request(make_beat(OP_INTERRUPT, 0, 0, 32'd0, 16'd1, 0));
      // interrupt for the watched one works before ready and gives zero
      send_request(make_beat(OP_INTERRUPT, 0, 0, 32'd0, 16'd0, 0));
      send_request(make_beat(OP_RESUME, 0, 0, 32'd0, 16'd5, 0));
      send_request(make_beat(OP_RESUME, 0, 0, 32'd0, 16'd0, 0));
      // arming trade on the uncounted side: no result
      send_request(make_beat(OP_TRADE, 0, 1, 32'd9, 16'd0, 1));
      // uncounted side once ready
      send_request(make_beat(OP_TRADE, 5, 1, 32'd9, 16'd0, 1));
      send_request(make_beat(OP_TRADE, 0, 0, 32'd0, 16'd0, 1));
      send_request(make_beat(OP_TRADE, 10, 0, 32'hFFFF_FFFF, 16'd0, 0));
      send_request(make_beat(OP_TRADE, 999, 0, 32'd1, 16'hFFFF, 1));
      // age equal to the window evicts the first entry
      send_request(make_beat(OP_TRADE, 1000, 0, 32'd7, 16'd0, 1));
      // clock going backwards stops eviction at once
      send_request(make_beat(OP_TRADE, 500, 0, 32'd3, 16'd0, 1));
      send_request(make_beat(OP_INTERRUPT, 0, 1, 32'd0, 16'd0, 1));
      // interrupted trade: queued, yet the total reads zero
      send_request(make_beat(OP_TRADE, 2000, 0, 32'd100, 16'd0, 1));
      send_request(make_beat(OP_RESUME, 0, 0, 32'd0, 16'd0, 1));
      // evicting the interrupted trade drives the total negative
      send_request(make_beat(OP_TRADE, 3500, 0, 32'd5, 16'd0, 1));
      send_request(make_beat(OP_TRADE, TIME_MAX, 0, 32'hFFFF_FFFF, 16'd0, 1));
      send_request(make_beat(OP_TRADE, TIME_MAX, 0, 32'd0, 16'hFFFF, 0));

      for (int p = 0; p < PHASES; p++) begin
         await_idle(SETTLE_CYCLES);
         case (p)
            0: begin
               window_len = TIME_W'(1); counted_side = 1'b0; watched_id = '0;
            end
            1: begin
               window_len = TIME_W'(WINDOW_MAX); counted_side = 1'b1; watched_id = '1;
            end
            2: begin
               // zero window: anything not in the future is evicted
               window_len = '0; counted_side = 1'b0; watched_id = SEC_W'($urandom());
            end
            3: begin
               window_len = WINDOW_RESET; counted_side = 1'b1; watched_id = '0;
            end
            4: begin
               window_len = TIME_W'($urandom_range(1, 5000)); counted_side = 1'b0;
               watched_id = '1;
            end
            5: begin
               window_len = TIME_W'(WINDOW_MAX); counted_side = 1'b0;
               watched_id = SEC_W'($urandom());
            end
            6: begin
               window_len = TIME_W'(200); counted_side = 1'b1;
               watched_id = SEC_W'($urandom());
            end
            default: begin
               window_len   = TIME_W'($urandom_range(1, WINDOW_MAX));
               counted_side = 1'($urandom_range(1));
               watched_id   = '0;
            end
         endcase
         // receiver slow then sender slow, last phases at full rate
         if (p < 3) begin
            send_idle_pct = 28; recv_idle_pct = 80;
         end else if (p < 6) begin
            send_idle_pct = 80; recv_idle_pct = 28;
         end else begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end
         write_register(CSR_WINDOW, CSR_DATA_W'(window_len));
         write_register(CSR_SIDE, CSR_DATA_W'(counted_side));
         write_register(CSR_WATCHED, CSR_DATA_W'(watched_id));
         // long receiver stall while the sender keeps pushing
         if (p == 6) hold_request = 1'b1;
         repeat (PHASE_ITEMS) send_request(random_beat());
      end

      await_idle(TAIL_CYCLES);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
